### rtl/core/ajst_pkg.sv
// Shared types and constants for the accelerometer jerk-spike tap detector.
package ajst_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WINDOW    = 2'd1,
		REG_NEEDED    = 2'd2,
		REG_COOLDOWN  = 2'd3
	} cfg_reg_t;

	// Item opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_MASK   = 1'b1;

	// Register reset values
	localparam logic [15:0] THRESHOLD_RST = 16'd737;
	localparam logic [15:0] WINDOW_RST    = 16'd900;
	localparam logic [2:0]  NEEDED_RST    = 3'd3;
	localparam logic [15:0] COOLDOWN_RST  = 16'd3500;

	// Status of one spike cell toward the compaction network
	typedef struct packed {
		logic        keep;
		logic [31:0] stamp;
	} cell_stat_t;

	// Registered squared axis changes
	typedef struct packed {
		logic [31:0] sq_x;
		logic [31:0] sq_y;
		logic [31:0] sq_z;
	} delta_sq_t;

endpackage

### rtl/core/accel_jerk_spike_tap_detector.sv
// Tap detector top level: stage one squares the change, stage two runs the spike cells.
//
// Takes one item per unstalled clock and returns one registered result per
// item. The first stage squares the change from the previous reading and the
// threshold; the second stage sums and compares, ages the SPIKE_SLOTS spike
// cells against the window, compacts the survivors, appends a new spike and
// updates the mask end time, all in the same cycle, so each item sees the state
// left by the one before it. The output register lets a new item enter while a
// result waits; input stall rises only when both stages hold items and the
// output is stalled. Registers may be written only while the block is idle.
module accel_jerk_spike_tap_detector #(
	parameter int SPIKE_SLOTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [31:0]        now_ms,
	input  logic               sample_ok,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [31:0]        mask_ms,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               pet_detected,
	output logic [2:0]         spikes_in_window,
	output logic               masked
);
	import ajst_pkg::*;

	localparam int CW = $clog2(SPIKE_SLOTS + 1);

	// Configuration registers
	logic [15:0] threshold_q;
	logic [15:0] window_q;
	logic [2:0]  needed_q;
	logic [15:0] cooldown_q;

	// Pipeline control
	logic s1_valid_q;
	logic out_valid_q;
	logic accept;
	logic adv;

	// Stage one payload
	logic        op_s1;
	logic [31:0] now_s1;
	logic        ok_s1;
	logic [31:0] mask_ms_s1;
	logic [31:0] thr2_s1;
	logic [31:0] thr2_c;
	delta_sq_t   sq_s1;

	// Block state
	logic          need_prime_q;
	logic [CW-1:0] fill_q;
	logic [31:0]   mask_until_q;

	// Result registers
	logic       pet_q;
	logic [2:0] count_q;
	logic       masked_q;

	// Stage two signals
	logic [33:0]   mag2;
	logic          spike;
	logic          is_mask;
	logic          is_blocked;
	logic          is_prime;
	logic          is_test;
	logic [CW-1:0] need_c;
	logic [CW-1:0] kept;
	logic          add;
	logic [CW-1:0] fill1;
	logic          det;
	logic [CW-1:0] fill_next;
	logic [CW-1:0] rank_c [SPIKE_SLOTS+1];
	cell_stat_t    cs [SPIKE_SLOTS];
	logic [31:0]   nstamp [SPIKE_SLOTS];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			window_q    <= WINDOW_RST;
			needed_q    <= NEEDED_RST;
			cooldown_q  <= COOLDOWN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_WINDOW:    window_q    <= cfg_data;
				REG_NEEDED:    needed_q    <= cfg_data[2:0];
				REG_COOLDOWN:  cooldown_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Handshake: stage two advances into the output register when it is free
	assign adv      = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage one: squared change and squared threshold
	ajst_delta u_delta (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.upd_prev ((op == OP_SAMPLE) && sample_ok),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.sq_s1    (sq_s1)
	);

	assign thr2_c = threshold_q * threshold_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			now_s1     <= now_ms;
			ok_s1      <= sample_ok;
			mask_ms_s1 <= mask_ms;
			thr2_s1    <= thr2_c;
		end
	end

	// Stage two: classify the item
	assign mag2       = 34'(sq_s1.sq_x) + 34'(sq_s1.sq_y) + 34'(sq_s1.sq_z);
	assign spike      = mag2 > {2'b00, thr2_s1};
	assign is_mask    = (op_s1 == OP_MASK);
	assign is_blocked = !is_mask && (now_s1 < mask_until_q);
	assign is_prime   = !is_mask && !is_blocked && ok_s1 && need_prime_q;
	assign is_test    = !is_mask && !is_blocked && ok_s1 && !need_prime_q;

	// Needed count clamped to one..slots
	always_comb begin
		if (needed_q == 3'd0) begin
			need_c = CW'(1);
		end else if (32'(needed_q) > SPIKE_SLOTS) begin
			need_c = CW'(SPIKE_SLOTS);
		end else begin
			need_c = CW'(needed_q);
		end
	end

	// Row of spike cells; the rank chain counts survivors below each cell
	assign rank_c[0] = '0;

	for (genvar i = 0; i < SPIKE_SLOTS; i++) begin : g_cell
		ajst_cell #(
			.CW (CW)
		) u_cell (
			.clk        (clk),
			.load       (adv && is_test),
			.load_stamp (nstamp[i]),
			.occupied   (CW'(i) < fill_q),
			.now_ms     (now_s1),
			.window_ms  (window_q),
			.rank_in    (rank_c[i]),
			.rank_out   (rank_c[i+1]),
			.stat       (cs[i])
		);
	end

	assign kept  = rank_c[SPIKE_SLOTS];
	assign add   = spike && (kept < need_c) && (kept < CW'(SPIKE_SLOTS));
	assign fill1 = kept + CW'(add);
	assign det   = spike && (fill1 >= need_c);

	// Compaction: survivor of rank j lands in cell j, new spike goes after them
	always_comb begin
		for (int j = 0; j < SPIKE_SLOTS; j++) begin
			nstamp[j] = '0;
			for (int i = 0; i < SPIKE_SLOTS; i++) begin
				if (cs[i].keep && (rank_c[i] == CW'(j))) begin
					nstamp[j] = cs[i].stamp;
				end
			end
			if (add && (kept == CW'(j))) begin
				nstamp[j] = now_s1;
			end
		end
	end

	// Next spike count
	always_comb begin
		if (is_blocked) begin
			fill_next = '0;
		end else if (is_test) begin
			fill_next = det ? '0 : fill1;
		end else begin
			fill_next = fill_q;
		end
	end

	// Block state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_prime_q <= 1'b1;
			fill_q       <= '0;
			mask_until_q <= '0;
		end else if (adv) begin
			fill_q <= fill_next;
			if (is_blocked) begin
				need_prime_q <= 1'b1;
			end else if (is_prime) begin
				need_prime_q <= 1'b0;
			end
			if (is_mask) begin
				mask_until_q <= now_s1 + mask_ms_s1;
			end else if (is_test && det) begin
				mask_until_q <= now_s1 + {16'd0, cooldown_q};
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			pet_q    <= is_test && det;
			count_q  <= 3'(fill_next);
			masked_q <= is_blocked;
		end
	end

	assign out_valid        = out_valid_q;
	assign pet_detected     = pet_q;
	assign spikes_in_window = count_q;
	assign masked           = masked_q;

`ifndef SYNTHESIS
	// Spike count never exceeds the cell row
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(SPIKE_SLOTS))
		else $error("spike count beyond cell count");

	// A detection empties the spike list
	a_det_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_test && det |=> fill_q == '0 && pet_q)
		else $error("detection left spikes behind");

	// A masked result reports neither detection nor spikes
	a_masked_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && masked_q |-> !pet_q && count_q == 3'd0)
		else $error("masked result carries detection or count");

	// Input stalls only when both stages are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q && out_stall)
		else $error("input stalled without a full pipeline");

	// A detection sets the mask end to now plus the cooldown
	a_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_test && det |=>
		mask_until_q == $past(now_s1) + {16'd0, $past(cooldown_q)})
		else $error("cooldown mask end wrong");
`endif

endmodule

### rtl/core/ajst_cell.sv
// One spike cell: holds a spike time, ages it against the window, passes its rank on.
module ajst_cell #(
	parameter int CW = 3
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic [31:0]           load_stamp,
	input  logic                  occupied,
	input  logic [31:0]           now_ms,
	input  logic [15:0]           window_ms,
	input  logic [CW-1:0]         rank_in,
	output logic [CW-1:0]         rank_out,
	output ajst_pkg::cell_stat_t  stat
);
	import ajst_pkg::*;

	logic [31:0] stamp_q;
	logic [31:0] age;
	logic        keep;

	// Stamp storage, rewritten on every spike test
	always_ff @(posedge clk) begin
		if (load) begin
			stamp_q <= load_stamp;
		end
	end

	// Age with wrapping subtraction
	assign age  = now_ms - stamp_q;
	assign keep = occupied && (age <= {16'd0, window_ms});

	// Kept cells below this one, plus this one
	assign rank_out   = rank_in + CW'(keep);
	assign stat.keep  = keep;
	assign stat.stamp = stamp_q;

endmodule

### rtl/core/ajst_delta.sv
// First stage: previous reading and registered squares of the per-axis change.
module ajst_delta (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic                 upd_prev,
	input  logic signed [15:0]   accel_x,
	input  logic signed [15:0]   accel_y,
	input  logic signed [15:0]   accel_z,
	output ajst_pkg::delta_sq_t  sq_s1
);
	import ajst_pkg::*;

	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic signed [15:0] prev_z_q;
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic signed [16:0] dz;
	logic signed [33:0] px;
	logic signed [33:0] py;
	logic signed [33:0] pz;

	// Previous reading; a masked sample may overwrite it since priming follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
		end else if (load && upd_prev) begin
			prev_x_q <= accel_x;
			prev_y_q <= accel_y;
			prev_z_q <= accel_z;
		end
	end

	// Exact 17-bit differences
	assign dx = {accel_x[15], accel_x} - {prev_x_q[15], prev_x_q};
	assign dy = {accel_y[15], accel_y} - {prev_y_q[15], prev_y_q};
	assign dz = {accel_z[15], accel_z} - {prev_z_q[15], prev_z_q};

	// Squares fit in 32 bits unsigned
	assign px = dx * dx;
	assign py = dy * dy;
	assign pz = dz * dz;

	always_ff @(posedge clk) begin
		if (load) begin
			sq_s1.sq_x <= px[31:0];
			sq_s1.sq_y <= py[31:0];
			sq_s1.sq_z <= pz[31:0];
		end
	end

endmodule
